### sv/smm_pkg.sv
// ----------------------------------------------------------------------------
// Square matrix multiply package
// Shared widths, function codes, data type and the MAC control bundle.
// ----------------------------------------------------------------------------
package smm_pkg;

	localparam int DATA_W      = 32;
	localparam int IDX_W       = 4;
	localparam int FUNC_W      = 2;
	localparam int SIZE_W      = 5;
	localparam int MAX_DIM_DEF = 16;
	localparam int SIZE_RESET  = 16;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

	typedef logic signed [DATA_W-1:0] data_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;   // start a new dot product
		logic valid;   // operand pair on the memory outputs is live
	} mac_ctrl_t;

endpackage

### sv/smm_ram.sv
// ----------------------------------------------------------------------------
// Matrix element store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smm_ram
	import smm_pkg::*;
#(
	parameter int DEPTH  = MAX_DIM_DEF * MAX_DIM_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  data_t             wdata,
	input  logic [ADDR_W-1:0] raddr,
	output data_t             rdata
);

	data_t mem [DEPTH];
	data_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/smm_mac.sv
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Registered 32x32 product followed by a wrapping 32-bit accumulator.
// ----------------------------------------------------------------------------
module smm_mac
	import smm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mac_ctrl_t ctrl,
	input  data_t     a,
	input  data_t     b,
	output logic      pending,
	output data_t     acc
);

	data_t prod_s2;
	logic  valid_s2;
	data_t acc_q;

	// Only the low 32 bits of the product matter, so sign does not.
	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign pending = valid_s2;
	assign acc     = acc_q;

endmodule

### sv/square_matrix_multiply.sv
// ----------------------------------------------------------------------------
// Square matrix multiply
// Loads two square signed matrices and returns single elements of A*B.
// ----------------------------------------------------------------------------
// A command beat is taken on a clock edge with start high and busy low. Load
// commands (A or B) finish in that same cycle and never raise busy, so loads
// can follow each other on every cycle; a load whose row or column is not
// below the size in effect is dropped. A read whose row or column is out of
// range returns a zero value with index_error set in the cycle after it is
// taken, also without raising busy. A read in range walks row "row" of A and
// column "col" of B through one multiply-accumulate unit, one element pair
// per cycle, because each matrix store has a single read port. Such a read
// holds busy while it issues each element pair and while the pairs pass
// through the memory read register, the product register and the
// last accumulate. The result is presented in the cycle right after busy
// falls, and a new command may be taken in that same cycle. Every result
// appears on product_value and index_error for exactly one cycle, marked by
// result_valid, and the receiver cannot stall it, so it must capture the
// beat when it appears. The size register is written through the cfg
// channel, which is always ready, and must only be written while the block
// is idle. A size above MAX_DIM acts as MAX_DIM. The element stores power up
// undefined and need no clearing; reading a product that uses an element
// never written gives an undefined value.
// ----------------------------------------------------------------------------
module square_matrix_multiply
	import smm_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  logic [FUNC_W-1:0] func,
	input  logic [IDX_W-1:0]  row_index,
	input  logic [IDX_W-1:0]  col_index,
	input  data_t             element_value,
	// result channel
	output logic              result_valid,
	output data_t             product_value,
	output logic              index_error,
	// size register write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data
);

	localparam int CELLS  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(CELLS);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]        state_q;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n_eff;
	logic [SIZE_W-1:0] n_q;
	logic [SIZE_W-1:0] k_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic              valid_s1;

	logic              accept;
	logic              in_range;
	logic              we_a;
	logic              we_b;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	data_t             a_s1;
	data_t             b_s1;

	mac_ctrl_t         mac_ctrl;
	logic              mac_pending;
	data_t             acc;

	logic              result_valid_q;
	data_t             product_value_q;
	logic              index_error_q;

	// The register may hold sizes beyond the storage; clamp to MAX_DIM.
	assign n_eff = (int'(size_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_q;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_range = ({1'b0, row_index} < n_eff) && ({1'b0, col_index} < n_eff);

	// Loads write straight into the stores in the cycle they are taken.
	assign waddr = ADDR_W'(int'(row_index) * MAX_DIM + int'(col_index));
	assign we_a  = accept && in_range && (func == FUNC_LOAD_A);
	assign we_b  = accept && in_range && (func == FUNC_LOAD_B);

	// Element k of the requested row of A and column of B.
	assign raddr_a = ADDR_W'(int'(row_q) * MAX_DIM + int'(k_q));
	assign raddr_b = ADDR_W'(int'(k_q) * MAX_DIM + int'(col_q));

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(SIZE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	smm_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (element_value),
		.raddr (raddr_a),
		.rdata (a_s1)
	);

	smm_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (element_value),
		.raddr (raddr_b),
		.rdata (b_s1)
	);

	assign mac_ctrl.clear = accept && in_range && (func == FUNC_READ);
	assign mac_ctrl.valid = valid_s1;

	smm_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mac_ctrl),
		.a       (a_s1),
		.b       (b_s1),
		.pending (mac_pending),
		.acc     (acc)
	);

	// Sequencer: issue one address pair per cycle, then wait for the
	// memory and product registers to empty before presenting the sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			k_q            <= '0;
		end else begin
			valid_s1       <= (state_q == ST_RUN);
			result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (func == FUNC_READ)) begin
						if (in_range) begin
							k_q     <= '0;
							state_q <= ST_RUN;
						end else begin
							result_valid_q <= 1'b1;
						end
					end
				end
				ST_RUN: begin
					k_q <= k_q + 1'b1;
					if (k_q == n_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !mac_pending) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Read operands and result payload.
	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_READ)) begin
			row_q <= row_index;
			col_q <= col_index;
			n_q   <= n_eff;
			if (!in_range) begin
				product_value_q <= '0;
				index_error_q   <= 1'b1;
			end
		end else if ((state_q == ST_DRAIN) && !valid_s1 && !mac_pending) begin
			product_value_q <= acc;
			index_error_q   <= 1'b0;
		end
	end

	assign result_valid  = result_valid_q;
	assign product_value = product_value_q;
	assign index_error   = index_error_q;

	// No result may appear while the dot product is still being issued.
	a_no_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !result_valid_q)
		else $error("result strobe while issuing operands");

	// The element counter never reaches the size of the read in flight.
	a_k_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q < n_q))
		else $error("element counter beyond matrix size");

	// Operand data is live only after an issue cycle.
	a_valid_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q == ST_RUN))
		else $error("operand valid without an issue");

	// A good product comes only out of the drain state.
	a_product_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !index_error_q) |-> $past(state_q == ST_DRAIN))
		else $error("product result without a finished dot product");

endmodule

### dv/product_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix product checker
// Mirrors both element stores and the size register from the observed beats
// and compares every result beat with the oldest predicted product element.
// ----------------------------------------------------------------------------
module product_checker
	import smm_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [FUNC_W-1:0] func,
	input  logic [IDX_W-1:0]  row_index,
	input  logic [IDX_W-1:0]  col_index,
	input  data_t             element_value,
	input  logic              result_valid,
	input  data_t             product_value,
	input  logic              index_error,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data,
	output int                mismatches,
	output int                results_pending
);

	typedef struct {
		logic [DATA_W-1:0] product;
		logic              index_error;
	} product_beat_t;

	logic [DATA_W-1:0] left_cells  [MAX_DIM][MAX_DIM];
	logic [DATA_W-1:0] right_cells [MAX_DIM][MAX_DIM];
	int unsigned       active_size;
	product_beat_t     products_due [$];

	// Row of A times column of B; each product and partial sum wraps at 32 bits.
	function automatic logic [DATA_W-1:0] dot_product(int unsigned r, int unsigned c);
		logic [DATA_W-1:0] sum;
		sum = '0;
		for (int k = 0; k < active_size; k++)
			sum = sum + left_cells[r][k] * right_cells[k][c];
		return sum;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		product_beat_t due;
		logic          in_range;
		if (!arst_n) begin
			active_size = SIZE_RESET;
			mismatches = 0;
			products_due.delete();
			results_pending <= 0;
		end else begin
			if (result_valid) begin
				if (products_due.size() == 0) begin
					mismatches++;
					$error("result beat with no read outstanding: product_value %h",
						product_value);
				end else begin
					due = products_due.pop_front();
					if (product_value !== due.product) begin
						mismatches++;
						$error("product_value: expected %h, actual %h",
							due.product, product_value);
					end
					if (index_error !== due.index_error) begin
						mismatches++;
						$error("index_error: expected %b, actual %b",
							due.index_error, index_error);
					end
				end
			end
			if (start && !busy) begin
				in_range = (row_index < active_size) && (col_index < active_size);
				case (func)
					FUNC_LOAD_A: begin
						if (in_range)
							left_cells[row_index][col_index] = element_value;
					end
					FUNC_LOAD_B: begin
						if (in_range)
							right_cells[row_index][col_index] = element_value;
					end
					FUNC_READ: begin
						due.product     = in_range ?
							dot_product(int'(row_index), int'(col_index)) : '0;
						due.index_error = !in_range;
						products_due    = {products_due, due};
					end
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready)
				active_size = (cfg_data > MAX_DIM) ? MAX_DIM : cfg_data;
			results_pending <= products_due.size();
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Square matrix multiply testbench
// Loads random matrices at many sizes and reads product elements back while
// the checker predicts each product beat and compares it field by field.
// ----------------------------------------------------------------------------
// The run opens with a short directed pass at size two: extreme element
// values whose products and sums wrap, every function code, reads and loads
// outside the matrix, the unused function code, size zero and a shrink after
// loading. Random phases follow, each with its own size (the oversized
// register values among them) and a sender idle rate from a list taken in turn.
//
// The block powers up with undefined element stores, so this module keeps a
// map of which elements were really written. A read in range is only issued
// once the whole row of A and column of B it walks are written; until then
// the read turns into a load of the first missing operand. That way most of
// the stimulus is well-formed load-then-read traffic with random content,
// mixed with out-of-range beats and the unused function code as noise.
//
// The result channel has no back-pressure, so only the sender idles. Before
// every size write the sender stops until every predicted product has come
// back, the block is not busy and a settling wait has passed, which keeps
// the register write on an idle block.
// ----------------------------------------------------------------------------
module tb;
	import smm_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int CLK_HALF        = 2;
	localparam int RESET_CYCLES    = 9;
	localparam int SETTLE_CYCLES   = 4;
	localparam int TAIL_CYCLES     = MAX_DIM_DEF + 8;
	localparam int ITEMS_PER_PHASE = 48;
	localparam int NUM_PHASES      = 10;
	localparam int CYCLE_LIMIT     = 200000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [FUNC_W-1:0] func;
	logic [IDX_W-1:0]  row_index;
	logic [IDX_W-1:0]  col_index;
	data_t             element_value;
	logic              result_valid;
	data_t             product_value;
	logic              index_error;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data;
	int                mismatches;
	int                results_pending;

	// Sizes of the random phases: small ones mostly, plus full size, the
	// oversized register values and zero.
	logic [SIZE_W-1:0] phase_sizes [NUM_PHASES] = '{3, 16, 1, 31, 0, 4, 17, 2, 6, 5};
	// Sender idle percentages, taken in turn by the phases.
	int unsigned       idle_mix [4] = '{0, 47, 0, 22};

	int unsigned cur_size;
	int unsigned idle_pct;
	int unsigned counted_items;
	int unsigned phase_target;
	int unsigned cycle_count;
	bit          a_loaded [MAX_DIM_DEF][MAX_DIM_DEF];
	bit          b_loaded [MAX_DIM_DEF][MAX_DIM_DEF];

	square_matrix_multiply uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.result_valid  (result_valid),
		.product_value (product_value),
		.index_error   (index_error),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	product_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.row_index       (row_index),
		.col_index       (col_index),
		.element_value   (element_value),
		.result_valid    (result_valid),
		.product_value   (product_value),
		.index_error     (index_error),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.results_pending (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Element values lean on the corners that make products and sums wrap.
	function automatic data_t pick_value();
		if ($urandom_range(4) != 0)
			return $urandom;
		case ($urandom_range(4))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return 32'sd1;
			default: return 32'sd0;
		endcase
	endfunction

	// Drives one command beat and holds it until the block takes it. Start is
	// left high on return, so a following beat goes out back to back.
	task automatic issue(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c, input data_t v);
		logic in_range;
		in_range = (r < cur_size) && (c < cur_size);
		start         <= 1'b1;
		func          <= f;
		row_index     <= r;
		col_index     <= c;
		element_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (in_range && f == FUNC_LOAD_A)
			a_loaded[r][c] = 1'b1;
		if (in_range && f == FUNC_LOAD_B)
			b_loaded[r][c] = 1'b1;
		// Ignored beats do not count toward the length of a phase.
		if (f == FUNC_READ || (in_range && (f == FUNC_LOAD_A || f == FUNC_LOAD_B)))
			counted_items++;
	endtask

	// Random sender gaps; the fields carry junk while start is low.
	task automatic pace();
		while ($urandom_range(99) < idle_pct) begin
			start         <= 1'b0;
			func          <= FUNC_W'($urandom);
			row_index     <= IDX_W'($urandom);
			col_index     <= IDX_W'($urandom);
			element_value <= $urandom;
			@(posedge clk);
		end
	endtask

	// Stops sending until every predicted product has come back and the block
	// is not busy, then waits for the block to settle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (results_pending != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(input logic [SIZE_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_size = (v > MAX_DIM_DEF) ? MAX_DIM_DEF : v;
	endtask

	task automatic random_item();
		int unsigned       pick;
		int unsigned       r;
		int unsigned       c;
		logic [FUNC_W-1:0] f;
		bit                done;
		pick = $urandom_range(99);
		case ($urandom_range(2))
			0: f = FUNC_LOAD_A;
			1: f = FUNC_LOAD_B;
			default: f = FUNC_READ;
		endcase
		if (pick < 5) begin
			issue(FUNC_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
		end else if (cur_size == 0) begin
			// Nothing lies inside a zero-sized matrix.
			issue(f, IDX_W'($urandom), IDX_W'($urandom), pick_value());
		end else if (pick < 13 && cur_size < MAX_DIM_DEF) begin
			// Row or column at or beyond the size in effect.
			r = $urandom_range(MAX_DIM_DEF - 1);
			c = $urandom_range(MAX_DIM_DEF - 1);
			if ($urandom_range(1))
				r = $urandom_range(MAX_DIM_DEF - 1, cur_size);
			else
				c = $urandom_range(MAX_DIM_DEF - 1, cur_size);
			issue(f, IDX_W'(r), IDX_W'(c), pick_value());
		end else if (pick < 50) begin
			// A read in range, once every operand it walks has been written.
			r = $urandom_range(cur_size - 1);
			c = $urandom_range(cur_size - 1);
			done = 1'b0;
			for (int k = 0; k < cur_size && !done; k++) begin
				if (!a_loaded[r][k]) begin
					issue(FUNC_LOAD_A, IDX_W'(r), IDX_W'(k), pick_value());
					done = 1'b1;
				end
			end
			for (int k = 0; k < cur_size && !done; k++) begin
				if (!b_loaded[k][c]) begin
					issue(FUNC_LOAD_B, IDX_W'(k), IDX_W'(c), pick_value());
					done = 1'b1;
				end
			end
			if (!done)
				issue(FUNC_READ, IDX_W'(r), IDX_W'(c), $urandom);
		end else begin
			issue($urandom_range(1) ? FUNC_LOAD_B : FUNC_LOAD_A,
				IDX_W'($urandom_range(cur_size - 1)),
				IDX_W'($urandom_range(cur_size - 1)), pick_value());
		end
	endtask

	// Watchdog: a run that has not finished by now has hung or lost a beat.
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		start         <= 1'b0;
		func          <= FUNC_LOAD_A;
		row_index     <= '0;
		col_index     <= '0;
		element_value <= '0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		cur_size      = SIZE_RESET;
		idle_pct      = 0;
		counted_items = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass at size two: the corner values make several products
		// and sums wrap.
		set_size(5'd2);
		issue(FUNC_LOAD_A, 4'd0, 4'd0, 32'sh7fff_ffff);
		issue(FUNC_LOAD_A, 4'd0, 4'd1, 32'sh8000_0000);
		issue(FUNC_LOAD_A, 4'd1, 4'd0, -32'sd1);
		issue(FUNC_LOAD_A, 4'd1, 4'd1, 32'sd1);
		issue(FUNC_LOAD_B, 4'd0, 4'd0, 32'sh7fff_ffff);
		issue(FUNC_LOAD_B, 4'd0, 4'd1, 32'sd0);
		issue(FUNC_LOAD_B, 4'd1, 4'd0, 32'sh8000_0000);
		issue(FUNC_LOAD_B, 4'd1, 4'd1, -32'sd1);
		issue(FUNC_READ, 4'd0, 4'd0, 32'sd0);
		issue(FUNC_READ, 4'd0, 4'd1, -32'sd1);
		issue(FUNC_READ, 4'd1, 4'd0, 32'sd0);
		issue(FUNC_READ, 4'd1, 4'd1, 32'sd0);
		// Reads outside the matrix return zero with the error flag.
		issue(FUNC_READ, 4'd2, 4'd0, 32'sd0);
		issue(FUNC_READ, 4'd0, 4'd15, 32'sd0);
		issue(FUNC_READ, 4'd15, 4'd15, 32'sd0);
		// A load outside the matrix and the unused code must change nothing.
		issue(FUNC_LOAD_A, 4'd1, 4'd15, 32'sd5);
		issue(FUNC_UNUSED, 4'd15, 4'd15, -32'sd1);
		issue(FUNC_READ, 4'd1, 4'd1, 32'sd0);
		// Size zero: the load is dropped and the read is out of range.
		set_size(5'd0);
		issue(FUNC_LOAD_B, 4'd0, 4'd0, 32'sd7);
		issue(FUNC_READ, 4'd0, 4'd0, 32'sd0);
		// Shrinking keeps element places; the read walks one pair only.
		set_size(5'd1);
		issue(FUNC_READ, 4'd0, 4'd0, 32'sd0);
		issue(FUNC_READ, 4'd0, 4'd1, 32'sd0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_size(phase_sizes[p]);
			idle_pct     = idle_mix[p % 4];
			phase_target = counted_items + ITEMS_PER_PHASE;
			while (counted_items < phase_target) begin
				pace();
				random_item();
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
sv/smm_pkg.sv
sv/smm_ram.sv
sv/smm_mac.sv
sv/square_matrix_multiply.sv
dv/product_checker.sv
dv/tb.sv
